FILE: hw/rtl/pcc_pkg.sv
// pcc_pkg: shared types, register codes and constants for the plane collision block.
// No dependencies; imported by pcc_front, pcc_back and the top level (not by pcc_queue).
package pcc_pkg;

	localparam int FRAC_BITS_DEF   = 24;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRIC_W          = 17;
	localparam int ONE_Q16         = 65536;
	localparam int CFG_IDX_W       = 3;
	localparam int MID_DEPTH       = 4;
	localparam int OUT_DEPTH       = 2;

	// Register map of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PLANE_PX,
		REG_PLANE_PY,
		REG_PLANE_PZ,
		REG_NORMAL_X,
		REG_NORMAL_Y,
		REG_NORMAL_Z,
		REG_FRICTION
	} pcc_reg_t;

	// How the back end forms the segment parameter t
	typedef enum logic [1:0] {
		MODE_ZERO,
		MODE_ONE,
		MODE_DIV
	} pcc_mode_t;

	typedef struct packed {
		logic      hit;
		pcc_mode_t mode;
	} pcc_flags_t;

	// Parallel-motion threshold at dot-product scale, never below one
	function automatic longint unsigned par_eps(input int fb);
		longint unsigned e;
		begin
			e = (64'd1 << (2 * fb)) / 64'd10000000000;
			par_eps = (e == 64'd0) ? 64'd1 : e;
		end
	endfunction

	// Surface offset 0.0001 in Q.fb, rounded
	function automatic longint unsigned lift_q(input int fb);
		begin
			lift_q = ((64'd1 << fb) + 64'd5000) / 64'd10000;
		end
	endfunction

endpackage

FILE: hw/rtl/pcc_queue.sv
// pcc_queue: small register FIFO used between front and back and at the output.
// No dependencies.
module pcc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] dout
);
	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTRW-1:0]  wp_q, rp_q;
	logic [CNTW-1:0]  cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CNTW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rp_q];

	// Store the incoming word
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= din;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PTRW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == PTRW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/pcc_front.sv
// pcc_front: takes positions, forms exact dot products and classifies the hit.
// Depends on pcc_pkg; feeds the mid queue.
module pcc_front import pcc_pkg::*; #(
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic [2:0][COORD_WIDTH-1:0]           cur,
	input  logic [2:0][COORD_WIDTH-1:0]           prev,
	input  logic [2:0][COORD_WIDTH-1:0]           plane,
	input  logic [2:0][COORD_WIDTH-1:0]           normal,
	output logic                                  mq_push,
	input  logic                                  mq_full,
	output pcc_flags_t                            flags,
	output logic [2*COORD_WIDTH+2:0]              an,
	output logic [2*COORD_WIDTH+2:0]              ad,
	output logic [2:0][COORD_WIDTH-1:0]           cur_o,
	output logic [2:0][COORD_WIDTH-1:0]           prev_o,
	output logic [2:0][COORD_WIDTH:0]             dir_o
);
	localparam int CW = COORD_WIDTH;
	localparam int DW = CW + 1;
	localparam int PW = 2 * CW + 1;
	localparam int SW = 2 * CW + 3;
	localparam logic [SW-1:0] EPS = SW'(par_eps(FRAC_BITS));

	logic adv, acc;
	logic v_s1, v_s2, v_s3, v_s4;

	logic [2:0][CW-1:0] cur_s1, cur_s2, cur_s3, cur_s4;
	logic [2:0][CW-1:0] prev_s1, prev_s2, prev_s3, prev_s4;
	logic [2:0][DW-1:0] dir_s1, dir_s2, dir_s3, dir_s4;

	logic signed [DW-1:0] dcp_s1 [3];
	logic signed [DW-1:0] dlp_s1 [3];
	logic signed [PW-1:0] pc_s2 [3];
	logic signed [PW-1:0] pl_s2 [3];
	logic signed [PW-1:0] pd_s2 [3];
	logic signed [SW-1:0] dc_s3, dl_s3, den_s3;
	logic [SW-1:0]        an_s4, ad_s4;
	logic                 coll_s4, dlz_s4, dlpos_s4, denneg_s4;

	// Stall the whole front when the last stage cannot hand off
	assign adv     = !v_s4 || !mq_full;
	assign full    = !adv;
	assign acc     = push && adv;
	assign mq_push = v_s4 && !mq_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1: offsets from plane point and motion direction
	always_ff @(posedge clk) begin
		if (adv) begin
			cur_s1  <= cur;
			prev_s1 <= prev;
			for (int i = 0; i < 3; i++) begin
				dcp_s1[i] <= DW'($signed(cur[i])) - DW'($signed(plane[i]));
				dlp_s1[i] <= DW'($signed(prev[i])) - DW'($signed(plane[i]));
				dir_s1[i] <= DW'($signed(cur[i])) - DW'($signed(prev[i]));
			end
		end
	end

	// Stage 2: products with the normal
	always_ff @(posedge clk) begin
		if (adv) begin
			cur_s2  <= cur_s1;
			prev_s2 <= prev_s1;
			dir_s2  <= dir_s1;
			for (int i = 0; i < 3; i++) begin
				pc_s2[i] <= PW'(dcp_s1[i]) * PW'($signed(normal[i]));
				pl_s2[i] <= PW'(dlp_s1[i]) * PW'($signed(normal[i]));
				pd_s2[i] <= PW'($signed(dir_s1[i])) * PW'($signed(normal[i]));
			end
		end
	end

	// Stage 3: dot product sums
	always_ff @(posedge clk) begin
		if (adv) begin
			cur_s3  <= cur_s2;
			prev_s3 <= prev_s2;
			dir_s3  <= dir_s2;
			dc_s3   <= SW'(pc_s2[0]) + SW'(pc_s2[1]) + SW'(pc_s2[2]);
			dl_s3   <= SW'(pl_s2[0]) + SW'(pl_s2[1]) + SW'(pl_s2[2]);
			den_s3  <= SW'(pd_s2[0]) + SW'(pd_s2[1]) + SW'(pd_s2[2]);
		end
	end

	// Stage 4: magnitudes and sign flags
	always_ff @(posedge clk) begin
		if (adv) begin
			cur_s4    <= cur_s3;
			prev_s4   <= prev_s3;
			dir_s4    <= dir_s3;
			an_s4     <= dl_s3[SW-1] ? SW'(-dl_s3) : SW'(dl_s3);
			ad_s4     <= den_s3[SW-1] ? SW'(-den_s3) : SW'(den_s3);
			coll_s4   <= dc_s3[SW-1] || (dc_s3 == '0) || dl_s3[SW-1];
			dlz_s4    <= (dl_s3 == '0);
			dlpos_s4  <= !dl_s3[SW-1] && (dl_s3 != '0);
			denneg_s4 <= den_s3[SW-1];
		end
	end

	// Classify: collision, parallel motion, and how t is formed
	always_comb begin
		flags.hit = coll_s4 && (ad_s4 >= EPS);
		if (dlz_s4 || (dlpos_s4 != denneg_s4)) begin
			flags.mode = MODE_ZERO;
		end else if (an_s4 >= ad_s4) begin
			flags.mode = MODE_ONE;
		end else begin
			flags.mode = MODE_DIV;
		end
	end

	assign an     = an_s4;
	assign ad     = ad_s4;
	assign cur_o  = cur_s4;
	assign prev_o = prev_s4;
	assign dir_o  = dir_s4;

endmodule

FILE: hw/rtl/pcc_back.sv
// pcc_back: divides out t one bit per stage, then applies lift and friction.
// Depends on pcc_pkg; reads the mid queue and feeds the output queue.
module pcc_back import pcc_pkg::*; #(
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        mq_empty,
	output logic                        mq_pop,
	input  pcc_flags_t                  flags,
	input  logic [2*COORD_WIDTH+2:0]    an,
	input  logic [2*COORD_WIDTH+2:0]    ad,
	input  logic [2:0][COORD_WIDTH-1:0] cur,
	input  logic [2:0][COORD_WIDTH-1:0] prev,
	input  logic [2:0][COORD_WIDTH:0]   dir,
	input  logic [2:0][COORD_WIDTH-1:0] normal,
	input  logic [FRIC_W-1:0]           friction,
	output logic                        oq_push,
	input  logic                        oq_full,
	output logic [2:0][COORD_WIDTH-1:0] new_pos,
	output logic                        corrected
);
	localparam int CW  = COORD_WIDTH;
	localparam int FB  = FRAC_BITS;
	localparam int DW  = CW + 1;
	localparam int MW  = 2 * CW + 3;
	localparam int TPW = FB + 2 + DW;
	localparam int LPW = FB + 2 + CW;
	localparam int CRW = CW + 2;
	localparam int PRW = CRW + FRIC_W + 1;
	localparam int SMW = CW + 4;
	localparam logic signed [FB+1:0]  LIFT_S = (FB+2)'(lift_q(FRAC_BITS));
	localparam logic signed [SMW-1:0] SMAX   = SMW'((64'd1 << (CW - 1)) - 64'd1);
	localparam logic signed [SMW-1:0] SMIN   = -SMAX - SMW'(1);

	logic adv;

	// Divider stages 0..FB
	logic               v_sk    [FB+1];
	logic [MW-1:0]      rem_sk  [FB+1];
	logic [MW-1:0]      ad_sk   [FB+1];
	logic [FB-1:0]      quo_sk  [FB+1];
	pcc_flags_t         flg_sk  [FB+1];
	logic [2:0][CW-1:0] cur_sk  [FB+1];
	logic [2:0][CW-1:0] prev_sk [FB+1];
	logic [2:0][DW-1:0] dir_sk  [FB+1];

	// Apply stages
	logic                  v_sa, v_sb, v_sc, v_sd;
	logic                  hit_sa, hit_sb, hit_sc, hit_sd;
	logic [2:0][CW-1:0]    cur_sa, cur_sb, cur_sc;
	logic [2:0][CW-1:0]    prev_sa, prev_sb, prev_sc;
	logic signed [TPW-1:0] tp_sa [3];
	logic signed [LPW-1:0] lf_sa [3];
	logic signed [CRW-1:0] corr_sb [3];
	logic signed [PRW-1:0] prod_sc [3];
	logic [2:0][CW-1:0]    new_sd;

	logic [FB:0]           t_w;
	logic [FRIC_W-1:0]     g_w;
	logic signed [SMW-1:0] sum_w [3];
	logic [2:0][CW-1:0]    res_w;

	// Stall the back end only when the result cannot leave
	assign adv     = !v_sd || !oq_full;
	assign mq_pop  = adv && !mq_empty;
	assign oq_push = v_sd && !oq_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sk[0] <= 1'b0;
		end else if (adv) begin
			v_sk[0] <= !mq_empty;
		end
	end

	// Load the divider from the queue head
	always_ff @(posedge clk) begin
		if (adv) begin
			rem_sk[0]  <= an;
			ad_sk[0]   <= ad;
			quo_sk[0]  <= '0;
			flg_sk[0]  <= flags;
			cur_sk[0]  <= cur;
			prev_sk[0] <= prev;
			dir_sk[0]  <= dir;
		end
	end

	// One restoring step per stage
	for (genvar k = 1; k <= FB; k++) begin : g_div
		logic [MW:0] r2;
		logic        ge;

		assign r2 = {rem_sk[k-1], 1'b0};
		assign ge = (r2 >= {1'b0, ad_sk[k-1]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sk[k] <= 1'b0;
			end else if (adv) begin
				v_sk[k] <= v_sk[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_sk[k]  <= ge ? MW'(r2 - {1'b0, ad_sk[k-1]}) : MW'(r2);
				quo_sk[k]  <= {quo_sk[k-1][FB-2:0], ge};
				ad_sk[k]   <= ad_sk[k-1];
				flg_sk[k]  <= flg_sk[k-1];
				cur_sk[k]  <= cur_sk[k-1];
				prev_sk[k] <= prev_sk[k-1];
				dir_sk[k]  <= dir_sk[k-1];
			end
		end
	end

	// Pick t from the classification
	always_comb begin
		unique case (flg_sk[FB].mode)
			MODE_ZERO: t_w = '0;
			MODE_ONE:  t_w = {1'b1, {FB{1'b0}}};
			default:   t_w = {1'b0, quo_sk[FB]};
		endcase
	end

	// Friction gain, one minus friction, clamped at zero when friction exceeds 1.0
	assign g_w = (friction > FRIC_W'(ONE_Q16)) ? '0 : FRIC_W'(ONE_Q16) - friction;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sa <= 1'b0;
			v_sb <= 1'b0;
			v_sc <= 1'b0;
			v_sd <= 1'b0;
		end else if (adv) begin
			v_sa <= v_sk[FB];
			v_sb <= v_sa;
			v_sc <= v_sb;
			v_sd <= v_sc;
		end
	end

	// Stage A: t times direction, offset times normal
	always_ff @(posedge clk) begin
		if (adv) begin
			hit_sa  <= flg_sk[FB].hit;
			cur_sa  <= cur_sk[FB];
			prev_sa <= prev_sk[FB];
			for (int i = 0; i < 3; i++) begin
				tp_sa[i] <= $signed({1'b0, t_w}) * $signed(dir_sk[FB][i]);
				lf_sa[i] <= LIFT_S * $signed(normal[i]);
			end
		end
	end

	// Stage B: floor both terms and add
	always_ff @(posedge clk) begin
		if (adv) begin
			hit_sb  <= hit_sa;
			cur_sb  <= cur_sa;
			prev_sb <= prev_sa;
			for (int i = 0; i < 3; i++) begin
				corr_sb[i] <= $signed(tp_sa[i][FB +: CRW]) + $signed(lf_sa[i][FB +: CRW]);
			end
		end
	end

	// Stage C: scale by friction gain
	always_ff @(posedge clk) begin
		if (adv) begin
			hit_sc  <= hit_sb;
			cur_sc  <= cur_sb;
			prev_sc <= prev_sb;
			for (int i = 0; i < 3; i++) begin
				prod_sc[i] <= $signed({1'b0, g_w}) * corr_sb[i];
			end
		end
	end

	// Stage D: add to previous position and saturate, or pass through
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_w[i] = SMW'($signed(prev_sc[i])) + $signed(prod_sc[i][16 +: SMW]);
			if (!hit_sc) begin
				res_w[i] = cur_sc[i];
			end else if (sum_w[i] > SMAX) begin
				res_w[i] = CW'(SMAX);
			end else if (sum_w[i] < SMIN) begin
				res_w[i] = CW'(SMIN);
			end else begin
				res_w[i] = CW'(sum_w[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_sd <= hit_sc;
			new_sd <= res_w;
		end
	end

	assign new_pos   = new_sd;
	assign corrected = hit_sd;

endmodule

FILE: hw/rtl/plane_collision_correct_top.sv
// Channel   Handshake            Payload
// in        push / full          cur_x..cur_z, prev_x..prev_z
// out       pop / empty          new_x..new_z, was_corrected
// cfg       cfg_valid/cfg_ready  cfg_index, cfg_data
// One item per cycle sustained unless a full queue stalls the pipeline. Path: 4 front stages,
// one queue slot, FRAC_BITS + 1 divider stages, 4 apply stages, output queue.
// The divider's one-quotient-bit-per-stage chain sets the latency.
// Reset clears control state and loads the default plane (y-up through origin).
// A full output queue stalls the back end; a full mid queue stalls the front.
// Top level: config registers, front, mid queue, back, output queue. Uses pcc_pkg.
module plane_collision_correct_top import pcc_pkg::*; #(
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [COORD_WIDTH-1:0] cur_x,
	input  logic [COORD_WIDTH-1:0] cur_y,
	input  logic [COORD_WIDTH-1:0] cur_z,
	input  logic [COORD_WIDTH-1:0] prev_x,
	input  logic [COORD_WIDTH-1:0] prev_y,
	input  logic [COORD_WIDTH-1:0] prev_z,
	input  logic                   pop,
	output logic                   empty,
	output logic [COORD_WIDTH-1:0] new_x,
	output logic [COORD_WIDTH-1:0] new_y,
	output logic [COORD_WIDTH-1:0] new_z,
	output logic                   was_corrected,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [COORD_WIDTH-1:0] cfg_data
);
	localparam int CW    = COORD_WIDTH;
	localparam int DW    = CW + 1;
	localparam int SW    = 2 * CW + 3;
	localparam int MID_W = $bits(pcc_flags_t) + 2 * SW + 6 * CW + 3 * DW;
	localparam int OUT_W = 3 * CW + 1;

	logic [2:0][CW-1:0]  plane_q, normal_q;
	logic [FRIC_W-1:0]   friction_q;

	logic                mq_push, mq_full, mq_pop, mq_empty;
	logic [MID_W-1:0]    mq_din, mq_dout;
	pcc_flags_t          f_flags, b_flags;
	logic [SW-1:0]       f_an, f_ad, b_an, b_ad;
	logic [2:0][CW-1:0]  f_cur, f_prev, b_cur, b_prev;
	logic [2:0][DW-1:0]  f_dir, b_dir;

	logic                oq_push, oq_full;
	logic [2:0][CW-1:0]  b_new;
	logic                b_corr;
	logic [OUT_W-1:0]    oq_din, oq_dout;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q     <= '0;
			normal_q    <= {CW'(0), CW'(1) << FRAC_BITS, CW'(0)};
			friction_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (pcc_reg_t'(cfg_index))
				REG_PLANE_PX: plane_q[0]  <= cfg_data;
				REG_PLANE_PY: plane_q[1]  <= cfg_data;
				REG_PLANE_PZ: plane_q[2]  <= cfg_data;
				REG_NORMAL_X: normal_q[0] <= cfg_data;
				REG_NORMAL_Y: normal_q[1] <= cfg_data;
				REG_NORMAL_Z: normal_q[2] <= cfg_data;
				REG_FRICTION: friction_q  <= cfg_data[FRIC_W-1:0];
				default: ;
			endcase
		end
	end

	pcc_front #(
		.FRAC_BITS   (FRAC_BITS),
		.COORD_WIDTH (COORD_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.cur     ({cur_z, cur_y, cur_x}),
		.prev    ({prev_z, prev_y, prev_x}),
		.plane   (plane_q),
		.normal  (normal_q),
		.mq_push (mq_push),
		.mq_full (mq_full),
		.flags   (f_flags),
		.an      (f_an),
		.ad      (f_ad),
		.cur_o   (f_cur),
		.prev_o  (f_prev),
		.dir_o   (f_dir)
	);

	// Mid queue between classification and correction
	assign mq_din = {f_flags, f_an, f_ad, f_cur, f_prev, f_dir};
	assign {b_flags, b_an, b_ad, b_cur, b_prev, b_dir} = mq_dout;

	pcc_queue #(
		.WIDTH (MID_W),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mq_push),
		.full   (mq_full),
		.din    (mq_din),
		.pop    (mq_pop),
		.empty  (mq_empty),
		.dout   (mq_dout)
	);

	pcc_back #(
		.FRAC_BITS   (FRAC_BITS),
		.COORD_WIDTH (COORD_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mq_empty  (mq_empty),
		.mq_pop    (mq_pop),
		.flags     (b_flags),
		.an        (b_an),
		.ad        (b_ad),
		.cur       (b_cur),
		.prev      (b_prev),
		.dir       (b_dir),
		.normal    (normal_q),
		.friction  (friction_q),
		.oq_push   (oq_push),
		.oq_full   (oq_full),
		.new_pos   (b_new),
		.corrected (b_corr)
	);

	// Output queue holds finished words until popped
	assign oq_din = {b_corr, b_new};
	assign {was_corrected, new_z, new_y, new_x} = oq_dout;

	pcc_queue #(
		.WIDTH (OUT_W),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (oq_push),
		.full   (oq_full),
		.din    (oq_din),
		.pop    (pop),
		.empty  (empty),
		.dout   (oq_dout)
	);

`ifndef NO_ASSERTIONS
	// Back end never pops an empty mid queue
	a_mq_pop: assert property (@(posedge clk) disable iff (!arst_n)
		mq_pop |-> !mq_empty) else $error("mid queue popped while empty");

	// Input stalls only when the mid queue is full
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> mq_full) else $error("input stalled with room in mid queue");

	// A full mid queue stays full until the back end takes a word
	a_mq_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mq_full && !mq_pop |=> mq_full) else $error("mid queue drained without pop");
`endif

endmodule
